// ----- hw/rtl/bre_pkg.sv -----
// Shared types for the Bresenham ellipse rasterizer.
// No dependencies; imported by bre_stepper and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bre_pkg;

	// Item kind carried on the input tuser bit
	typedef enum logic {
		ACT_START = 1'b0,
		ACT_STEP  = 1'b1
	} action_t;

	// Move chosen by the error term
	typedef enum logic [1:0] {
		MV_HORZ = 2'd0,
		MV_VERT = 2'd1,
		MV_DIAG = 2'd2
	} move_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bre_stepper.sv -----
// Ellipse state, per-step error update and the result register.
// Depends on bre_pkg; instantiated by bresenham_ellipse_rasterizer_top.
`timescale 1ns / 1ps
`default_nettype none

module bre_stepper import bre_pkg::*; #(
	parameter int COORD_BITS = 11,
	parameter int AXIS_BITS  = 10
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// item from the product stage
	input  wire logic                    item_valid,
	output logic                         item_ready,
	input  wire action_t                 item_action,
	input  wire logic [COORD_BITS-1:0]   item_cx,
	input  wire logic [COORD_BITS-1:0]   item_cy,
	input  wire logic [AXIS_BITS-1:0]    item_a,
	input  wire logic [AXIS_BITS-1:0]    item_b,
	input  wire logic [2*AXIS_BITS-1:0]  item_a2,
	input  wire logic [2*AXIS_BITS-1:0]  item_b2,
	input  wire logic [2*AXIS_BITS-1:0]  item_ab,
	// result
	output logic                         res_valid,
	input  wire logic                    res_ready,
	output logic [COORD_BITS+1:0]        res_x_right,
	output logic [COORD_BITS+1:0]        res_x_left,
	output logic [COORD_BITS+1:0]        res_y_lower,
	output logic [COORD_BITS+1:0]        res_y_upper,
	output logic                         res_last
);

	localparam int OUT_W  = COORD_BITS + 2;
	localparam int XOFF_W = AXIS_BITS + 1;
	localparam int YOFF_W = AXIS_BITS + 2;
	localparam int SQ_W   = 2 * AXIS_BITS;
	localparam int CUBE_W = 3 * AXIS_BITS;
	localparam int ERR_W  = 2 * AXIS_BITS + 14;
	localparam int ACC_W  = 3 * AXIS_BITS + 2;
	localparam int BIG_W  = (ERR_W > ACC_W) ? ERR_W : ACC_W;
	localparam int T_W    = ((BIG_W > COORD_BITS) ? BIG_W : COORD_BITS) + 3;

	// ellipse state
	logic                     active_q;
	logic [COORD_BITS-1:0]    cx_q;
	logic [COORD_BITS-1:0]    cy_q;
	logic [SQ_W-1:0]          a2_q;
	logic [SQ_W-1:0]          b2_q;
	logic [XOFF_W-1:0]        x_q;
	logic [YOFF_W-1:0]        y_q;
	logic [ERR_W-1:0]         d_q;
	logic [ACC_W-1:0]         ay_q;   // a2 * y, kept incrementally
	logic [ACC_W-1:0]         bx_q;   // b2 * x, kept incrementally

	logic                     emit;
	logic                     go;
	logic [CUBE_W-1:0]        a2b;
	logic signed [T_W-1:0]    d0;
	move_t                    move;
	logic [XOFF_W-1:0]        x_n;
	logic [YOFF_W-1:0]        y_n;
	logic signed [T_W-1:0]    d_n;
	logic signed [T_W-1:0]    ay_n;
	logic signed [T_W-1:0]    bx_n;
	logic [OUT_W-1:0]         xr_n;
	logic [OUT_W-1:0]         xl_n;
	logic [OUT_W-1:0]         yl_n;
	logic [OUT_W-1:0]         yu_n;

	assign emit       = (item_action == ACT_STEP) && active_q;
	assign item_ready = !emit || !res_valid || res_ready;
	assign go         = item_valid && item_ready;

	// start: d0 = b2 - 2*a2*b, with a2*b formed as a * (a*b)
	assign a2b = CUBE_W'(item_a) * CUBE_W'(item_ab);
	assign d0  = signed'(T_W'(item_b2)) - (signed'(T_W'(a2b)) <<< 1);

	always_comb begin
		logic signed [T_W-1:0] d_t;
		logic signed [T_W-1:0] ay_t;
		logic signed [T_W-1:0] bx_t;
		logic signed [T_W-1:0] a2_t;
		logic signed [T_W-1:0] b2_t;
		logic signed [T_W-1:0] y_t;
		logic signed [T_W-1:0] x_t;
		logic signed [T_W-1:0] cx_t;
		logic signed [T_W-1:0] cy_t;
		logic signed [T_W-1:0] t1;
		logic signed [T_W-1:0] t2;
		logic                  d_neg;
		logic                  d_pos;

		d_t  = T_W'(signed'(d_q));
		ay_t = T_W'(signed'(ay_q));
		bx_t = T_W'(signed'(bx_q));
		y_t  = T_W'(signed'(y_q));
		a2_t = signed'(T_W'(a2_q));
		b2_t = signed'(T_W'(b2_q));
		x_t  = signed'(T_W'(x_q));
		cx_t = signed'(T_W'(cx_q));
		cy_t = signed'(T_W'(cy_q));

		// quad of the current position
		xr_n = OUT_W'(cx_t + x_t);
		xl_n = OUT_W'(cx_t - x_t);
		yl_n = OUT_W'(cy_t + y_t);
		yu_n = OUT_W'(cy_t - y_t);

		t1    = ((d_t + ay_t) <<< 1) - a2_t;
		t2    = ((d_t - bx_t) <<< 1) - b2_t;
		d_neg = d_q[ERR_W-1];
		d_pos = !d_neg && (d_q != '0);

		if (d_neg && (t1[T_W-1] || (t1 == '0))) begin
			move = MV_HORZ;
		end else if (d_pos && !t2[T_W-1] && (t2 != '0)) begin
			move = MV_VERT;
		end else begin
			move = MV_DIAG;
		end

		bx_n = bx_t + b2_t;
		ay_n = ay_t - a2_t;

		case (move)
			MV_HORZ: begin
				x_n = x_q + XOFF_W'(1);
				y_n = y_q;
				d_n = d_t + (bx_n <<< 1) + b2_t;
			end
			MV_VERT: begin
				x_n = x_q;
				y_n = y_q - YOFF_W'(1);
				d_n = d_t + a2_t - (ay_n <<< 1);
			end
			default: begin
				x_n = x_q + XOFF_W'(1);
				y_n = y_q - YOFF_W'(1);
				d_n = d_t + ((bx_n - ay_n) <<< 1) + a2_t + b2_t;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (go && emit) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			if (go) begin
				if (item_action == ACT_START) begin
					active_q <= 1'b1;
				end else if (emit && y_n[YOFF_W-1]) begin
					// drop out once y has gone below zero
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (item_action == ACT_START) begin
				cx_q <= item_cx;
				cy_q <= item_cy;
				a2_q <= item_a2;
				b2_q <= item_b2;
				x_q  <= '0;
				y_q  <= YOFF_W'(item_b);
				d_q  <= d0[ERR_W-1:0];
				ay_q <= ACC_W'(a2b);
				bx_q <= '0;
			end else if (emit) begin
				x_q         <= x_n;
				y_q         <= y_n;
				d_q         <= d_n[ERR_W-1:0];
				if (move != MV_VERT) begin
					bx_q <= bx_n[ACC_W-1:0];
				end
				if (move != MV_HORZ) begin
					ay_q <= ay_n[ACC_W-1:0];
				end
				res_x_right <= xr_n;
				res_x_left  <= xl_n;
				res_y_lower <= yl_n;
				res_y_upper <= yu_n;
				res_last    <= y_n[YOFF_W-1];
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bresenham_ellipse_rasterizer_top.sv -----
// Bresenham ellipse rasterizer: one symmetric pixel quad per step transaction.
// A step transaction passes the input register and the product stage before it reaches the result register.
// Throughput: one transaction per clock unless the output stalls steps; the error loop is a registered adder stage.
// Start transactions and steps while idle produce no output transaction.
// Reset empties the pipeline and leaves the ellipse idle.
// Depends on bre_pkg and bre_stepper.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_ellipse_rasterizer_top import bre_pkg::*; #(
	parameter int COORD_BITS = 11,
	parameter int AXIS_BITS  = 10
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// center_x, center_y, axis_a, axis_b (from bit 0 up), zero padded
	input  wire logic [((2*COORD_BITS+2*AXIS_BITS+7)/8)*8-1:0] s_axis_tdata,
	// action
	input  wire logic s_axis_tuser,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// x_right, x_left, y_lower, y_upper (from bit 0 up), zero padded
	output logic [((4*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
	// last
	output logic      m_axis_tlast
);

	localparam int C     = COORD_BITS;
	localparam int A     = AXIS_BITS;
	localparam int OUT_W = COORD_BITS + 2;
	localparam int OTD_W = ((4*(COORD_BITS+2)+7)/8)*8;

	// input register
	logic              valid_s1;
	action_t           act_s1;
	logic [C-1:0]      cx_s1;
	logic [C-1:0]      cy_s1;
	logic [A-1:0]      a_s1;
	logic [A-1:0]      b_s1;

	// product stage
	logic              valid_s2;
	action_t           act_s2;
	logic [C-1:0]      cx_s2;
	logic [C-1:0]      cy_s2;
	logic [A-1:0]      a_s2;
	logic [A-1:0]      b_s2;
	logic [2*A-1:0]    a2_s2;
	logic [2*A-1:0]    b2_s2;
	logic [2*A-1:0]    ab_s2;

	logic              item_ready;
	logic              go_s1;
	logic [OUT_W-1:0]  x_right;
	logic [OUT_W-1:0]  x_left;
	logic [OUT_W-1:0]  y_lower;
	logic [OUT_W-1:0]  y_upper;

	assign go_s1         = valid_s1 && (!valid_s2 || item_ready);
	assign s_axis_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1) begin
				valid_s2 <= 1'b1;
			end else if (valid_s2 && item_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			act_s1 <= action_t'(s_axis_tuser);
			cx_s1  <= s_axis_tdata[C-1:0];
			cy_s1  <= s_axis_tdata[2*C-1:C];
			a_s1   <= s_axis_tdata[2*C+A-1:2*C];
			b_s1   <= s_axis_tdata[2*C+2*A-1:2*C+A];
		end
		// squares and a*b for a start; steps carry them along unused
		if (go_s1) begin
			act_s2 <= act_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			a2_s2  <= (2*A)'(a_s1) * (2*A)'(a_s1);
			b2_s2  <= (2*A)'(b_s1) * (2*A)'(b_s1);
			ab_s2  <= (2*A)'(a_s1) * (2*A)'(b_s1);
		end
	end

	bre_stepper #(
		.COORD_BITS (COORD_BITS),
		.AXIS_BITS  (AXIS_BITS)
	) u_stepper (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s2),
		.item_ready  (item_ready),
		.item_action (act_s2),
		.item_cx     (cx_s2),
		.item_cy     (cy_s2),
		.item_a      (a_s2),
		.item_b      (b_s2),
		.item_a2     (a2_s2),
		.item_b2     (b2_s2),
		.item_ab     (ab_s2),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_x_right (x_right),
		.res_x_left  (x_left),
		.res_y_lower (y_lower),
		.res_y_upper (y_upper),
		.res_last    (m_axis_tlast)
	);

	assign m_axis_tdata = OTD_W'({y_upper, y_lower, x_left, x_right});

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the Bresenham ellipse rasterizer top level.
// Predicts every pixel quad in-bench and compares it with the output stream; needs bre_pkg.
`timescale 1ns / 1ps

module tb;
	import bre_pkg::*;

	localparam int ITEMS_TARGET = 1550;
	localparam int LONG_HOLD    = 300;
	localparam int IDLE_LIMIT   = 4000;
	localparam int RUN_TO_END   = 100000;

	typedef struct packed {
		logic signed [12:0] x_right;
		logic signed [12:0] x_left;
		logic signed [12:0] y_lower;
		logic signed [12:0] y_upper;
		logic               last;
	} quad_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;

	// predicted rasterizer state
	logic [10:0]        ell_col, ell_row;
	longint             ell_a_sq, ell_b_sq;
	logic [10:0]        ell_x;
	logic signed [11:0] ell_y;
	logic signed [33:0] ell_err;
	bit                 ell_busy;

	quad_t expected_quads[$];
	quad_t got_quad, want_quad;

	bit tx_no_gap, rx_no_stall;
	int hold_requests, hold_served, rx_wait;
	int items_used, ellipses_started, ellipses_done, quads_checked, mismatches, idle_cycles;

	bresenham_ellipse_rasterizer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the ellipse by one input transaction; returns 1 when a quad comes out.
	function automatic bit ellipse_advance(input action_t act, input logic [10:0] cx_in,
			input logic [10:0] cy_in, input logic [9:0] a_in, input logic [9:0] b_in,
			output quad_t q);
		longint cx, cy, x, y, d, t;
		q = '0;
		if (act == ACT_START) begin
			ell_col = cx_in;
			ell_row = cy_in;
			ell_a_sq = longint'(a_in) * longint'(a_in);
			ell_b_sq = longint'(b_in) * longint'(b_in);
			ell_x = '0;
			ell_y = 12'(longint'(b_in));
			ell_err = 34'(ell_b_sq - 2 * ell_a_sq * longint'(b_in));
			ell_busy = 1'b1;
			return 1'b0;
		end
		if (!ell_busy)
			return 1'b0;
		cx = longint'(ell_col);
		cy = longint'(ell_row);
		x = longint'(ell_x);
		y = longint'(ell_y);
		d = longint'(ell_err);
		q.x_right = 13'(cx + x);
		q.x_left  = 13'(cx - x);
		q.y_lower = 13'(cy + y);
		q.y_upper = 13'(cy - y);
		t = 2 * (d + ell_a_sq * y) - ell_a_sq;
		if (d < 0 && t <= 0) begin
			x = x + 1;
			d = d + ell_b_sq * (2 * x + 1);
		end else begin
			t = 2 * (d - ell_b_sq * x) - ell_b_sq;
			if (d > 0 && t > 0) begin
				y = y - 1;
				d = d + ell_a_sq * (1 - 2 * y);
			end else begin
				x = x + 1;
				y = y - 1;
				d = d + 2 * (x * ell_b_sq - y * ell_a_sq) + ell_a_sq + ell_b_sq;
			end
		end
		ell_x = 11'(x);
		ell_y = 12'(y);
		ell_err = 34'(d);
		if (ell_y < 0) begin
			ell_busy = 1'b0;
			q.last = 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic send_item(input action_t act, input logic [10:0] cx, input logic [10:0] cy,
			input logic [9:0] a, input logic [9:0] b);
		int gap;
		quad_t q;
		bit made;
		gap = tx_no_gap ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {6'd0, b, a, cy, cx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		made = ellipse_advance(act, cx, cy, a, b, q);
		if (made)
			expected_quads.push_back(q);
		if (act == ACT_START || made)
			items_used++;
	endtask

	// Step fields are ignored by the block, so fill them with noise.
	task automatic send_step();
		send_item(ACT_STEP, 11'($urandom), 11'($urandom), 10'($urandom), 10'($urandom));
	endtask

	task automatic run_ellipse(input logic [10:0] cx, input logic [10:0] cy,
			input logic [9:0] a, input logic [9:0] b, input int max_steps);
		int n;
		send_item(ACT_START, cx, cy, a, b);
		ellipses_started++;
		n = 0;
		while (ell_busy && n < max_steps) begin
			send_step();
			n++;
		end
	endtask

	task automatic test_directed();
		tx_no_gap = 1'b0;
		rx_no_stall = 1'b0;
		send_step();                                             // idle: dropped
		run_ellipse(11'd2047, 11'd2047, 10'd1023, 10'd1023, 4);  // abandoned by next start
		run_ellipse(11'd0, 11'd0, 10'd3, 10'd2, RUN_TO_END);     // negative left and upper
		run_ellipse(11'd1024, 11'd0, 10'd1023, 10'd0, RUN_TO_END); // flat: one quad only
		send_step();
		run_ellipse(11'd5, 11'd2047, 10'd0, 10'd5, RUN_TO_END);  // vertical segment
		run_ellipse(11'd0, 11'd0, 10'd0, 10'd0, RUN_TO_END);
	endtask

	// Hold the output off while steps keep coming, so the input side backs up.
	task automatic test_output_stall();
		tx_no_gap = 1'b1;
		rx_no_stall = 1'b1;
		hold_requests++;
		run_ellipse(11'd300, 11'd400, 10'd40, 10'd30, RUN_TO_END);
		tx_no_gap = 1'b0;
		rx_no_stall = 1'b0;
	endtask

	task automatic test_random();
		int kind;
		logic [10:0] cx, cy;
		logic [9:0] a, b;
		while (items_used < ITEMS_TARGET) begin
			kind = $urandom_range(0, 19);
			tx_no_gap = ($urandom_range(0, 3) == 0);
			rx_no_stall = ($urandom_range(0, 3) == 0);
			cx = 11'($urandom);
			cy = 11'($urandom);
			if (kind < 2) begin
				repeat ($urandom_range(1, 3)) send_step();
			end else if (kind < 5) begin
				// full-range axes, cut short by the next start
				run_ellipse(cx, cy, 10'($urandom), 10'($urandom), $urandom_range(0, 30));
			end else begin
				a = (kind < 8) ? 10'($urandom_range(0, 63)) : 10'($urandom_range(0, 15));
				b = (kind < 8) ? 10'($urandom_range(0, 63)) : 10'($urandom_range(0, 15));
				run_ellipse(cx, cy, a, b, RUN_TO_END);
				if ($urandom_range(0, 3) == 0)
					send_step();
			end
		end
	endtask

	initial begin
		ell_col = '0;
		ell_row = '0;
		ell_a_sq = 0;
		ell_b_sq = 0;
		ell_x = '0;
		ell_y = '0;
		ell_err = '0;
		ell_busy = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_output_stall();
		test_random();
		s_axis_tvalid <= 1'b0;
		while (expected_quads.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Ran %0d ellipse starts (%0d traced to the last quad), %0d input items.",
			ellipses_started, ellipses_done, items_used);
		$display("Checked %0d pixel quads, with random gaps and one long output hold.",
			quads_checked);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Output side: random stalls between transactions, plus the long hold on request.
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			rx_wait = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (m_axis_tready && m_axis_tvalid) begin
			rx_wait = rx_no_stall ? 0 : $urandom_range(0, 8);
			if (rx_wait != 0)
				m_axis_tready <= 1'b0;
		end else if (!m_axis_tready) begin
			if (rx_wait > 0)
				rx_wait--;
			if (rx_wait == 0)
				m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_quad.x_right = m_axis_tdata[12:0];
			got_quad.x_left  = m_axis_tdata[25:13];
			got_quad.y_lower = m_axis_tdata[38:26];
			got_quad.y_upper = m_axis_tdata[51:39];
			got_quad.last    = m_axis_tlast;
			if (expected_quads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected quad: xr=%0d xl=%0d yl=%0d yu=%0d last=%0b",
						got_quad.x_right, got_quad.x_left, got_quad.y_lower,
						got_quad.y_upper, got_quad.last);
			end else begin
				want_quad = expected_quads.pop_front();
				quads_checked++;
				if (want_quad.last)
					ellipses_done++;
				if (got_quad !== want_quad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("quad %0d mismatch: expected xr=%0d xl=%0d yl=%0d yu=%0d ",
							quads_checked, want_quad.x_right, want_quad.x_left,
							want_quad.y_lower, want_quad.y_upper,
							"last=%0b, got xr=%0d xl=%0d yl=%0d yu=%0d last=%0b",
							want_quad.last,
							got_quad.x_right, got_quad.x_left, got_quad.y_lower,
							got_quad.y_upper, got_quad.last);
				end
			end
		end
	end

	// Watchdog: end the run if neither side moves a transaction for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a transaction", idle_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule

// ----- filelist.f -----
hw/rtl/bre_pkg.sv
hw/rtl/bre_stepper.sv
hw/rtl/bresenham_ellipse_rasterizer_top.sv
sim/tb.sv
